// ----- rtl/cbti_pkg.sv -----
// Shared constants, types and a helper function for the clamped bilinear table interpolator.
package cbti_pkg;

    localparam int MAX_X_POINTS = 64;
    localparam int MAX_Y_POINTS = 64;
    localparam int FRAC_BITS    = 16;

    localparam int MAX_POINTS = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
    localparam int GRID_DEPTH = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int XAW        = $clog2(MAX_X_POINTS);
    localparam int YAW        = $clog2(MAX_Y_POINTS);
    localparam int KW         = $clog2(MAX_POINTS);
    localparam int CW         = $clog2(MAX_POINTS + 1);
    localparam int GAW        = $clog2(GRID_DEPTH);
    localparam int FW         = FRAC_BITS + 1;
    localparam int PW         = 32 + FW + 1;
    localparam int DCW        = $clog2(FRAC_BITS);

    localparam logic [1:0] KIND_QUERY  = 2'd0;
    localparam logic [1:0] KIND_LOAD_X = 2'd1;
    localparam logic [1:0] KIND_LOAD_Y = 2'd2;
    localparam logic [1:0] KIND_LOAD_G = 2'd3;

    localparam logic REG_X_POINTS = 1'b0;
    localparam logic REG_Y_POINTS = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LO, ST_HI, ST_CLAMP, ST_SCAN, ST_R0, ST_R1, ST_DIV,
        ST_GBASE, ST_G00, ST_M00, ST_M10, ST_M01, ST_M11, ST_C1, ST_MU0,
        ST_MU1, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_LO, OP_HI, OP_CLAMP, OP_SCAN, OP_R0, OP_R1,
        OP_DIV, OP_GBASE, OP_G00, OP_M00, OP_M10, OP_M01, OP_M11, OP_C1,
        OP_MU0, OP_MU1, OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic axis;
    } t_cmd;

    typedef struct packed {
        logic top;
        logic scan_end;
        logic div_trivial;
        logic div_last;
    } t_stat;

    function automatic logic [CW-1:0] eff_count(input logic [6:0] n, input int maxn);
        int v;
        v = int'(n);
        if (v < 2) v = 2;
        if (v > maxn) v = maxn;
        return CW'(v);
    endfunction

endpackage

// ----- rtl/cbti_ctrl.sv -----
// Sequencing state machine for loads, axis bracketing, division and the blend.
module cbti_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_kind,
    input  logic            i_out_ready,
    input  cbti_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output cbti_pkg::t_cmd  o_cmd
);
    import cbti_pkg::*;

    t_state r_state, n_state;
    logic   r_axis, n_axis;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_axis   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_ovalid   = r_ovalid && !i_out_ready;
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.axis = r_axis;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.op = OP_ACCEPT;
                    if (i_kind == KIND_QUERY) begin
                        n_axis  = 1'b0;
                        n_state = ST_LO;
                    end
                end
            end
            ST_LO: begin
                o_cmd.op = OP_LO;
                n_state  = ST_HI;
            end
            ST_HI: begin
                o_cmd.op = OP_HI;
                n_state  = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd.op = OP_CLAMP;
                n_state  = i_stat.top ? ST_R0 : ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_stat.scan_end) n_state = ST_R0;
            end
            ST_R0: begin
                o_cmd.op = OP_R0;
                n_state  = ST_R1;
            end
            ST_R1: begin
                o_cmd.op = OP_R1;
                if (!i_stat.div_trivial) begin
                    n_state = ST_DIV;
                end else if (r_axis) begin
                    n_state = ST_GBASE;
                end else begin
                    n_axis  = 1'b1;
                    n_state = ST_LO;
                end
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_stat.div_last) begin
                    if (r_axis) begin
                        n_state = ST_GBASE;
                    end else begin
                        n_axis  = 1'b1;
                        n_state = ST_LO;
                    end
                end
            end
            ST_GBASE: begin
                o_cmd.op = OP_GBASE;
                n_state  = ST_G00;
            end
            ST_G00: begin
                o_cmd.op = OP_G00;
                n_state  = ST_M00;
            end
            ST_M00: begin
                o_cmd.op = OP_M00;
                n_state  = ST_M10;
            end
            ST_M10: begin
                o_cmd.op = OP_M10;
                n_state  = ST_M01;
            end
            ST_M01: begin
                o_cmd.op = OP_M01;
                n_state  = ST_M11;
            end
            ST_M11: begin
                o_cmd.op = OP_M11;
                n_state  = ST_C1;
            end
            ST_C1: begin
                o_cmd.op = OP_C1;
                n_state  = ST_MU0;
            end
            ST_MU0: begin
                o_cmd.op = OP_MU0;
                n_state  = ST_MU1;
            end
            ST_MU1: begin
                o_cmd.op = OP_MU1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.op = OP_OUT;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule

// ----- rtl/cbti_dp.sv -----
// Datapath with the axis and grid memories, scan, serial divider and blend multiplier.
module cbti_dp (
    input  logic                       i_clk,
    input  cbti_pkg::t_cmd             i_cmd,
    input  logic [1:0]                 i_kind,
    input  logic [11:0]                i_entry_index,
    input  logic signed [31:0]         i_entry_value,
    input  logic signed [31:0]         i_query_x,
    input  logic signed [31:0]         i_query_y,
    input  logic [cbti_pkg::CW-1:0]    i_nx,
    input  logic [cbti_pkg::CW-1:0]    i_ny,
    output cbti_pkg::t_stat            o_stat,
    output logic signed [31:0]         o_result
);
    import cbti_pkg::*;

    localparam logic [FW-1:0] FRAC_ONE = FW'(1) << FRAC_BITS;

    logic signed [31:0] xt [MAX_X_POINTS];
    logic signed [31:0] yt [MAX_Y_POINTS];
    logic signed [31:0] grid [GRID_DEPTH];

    logic signed [31:0] r_qx, r_qy, r_rd, r_lo, r_c, r_t0, r_g, r_c0, r_c1, r_res;
    logic [CW-1:0]      r_nx, r_ny;
    logic [KW-1:0]      r_k, r_idx, r_ix, r_iy;
    logic signed [32:0] r_d, r_rem;
    logic [FRAC_BITS-1:0] r_q;
    logic [DCW-1:0]     r_cnt;
    logic [FW-1:0]      r_fx, r_fy;
    logic [GAW-1:0]     r_base;
    logic signed [PW-1:0] r_p, r_acc;

    logic [KW-1:0]      rd_addr;
    logic [GAW-1:0]     g_addr;
    logic [CW-1:0]      n_cur;
    logic signed [31:0] q_cur, c1v, cv;
    logic               top, hit, last;
    logic signed [32:0] dv, diff;
    logic [33:0]        rem2;
    logic               qbit;
    logic [FRAC_BITS-1:0] q_next;
    logic [FW-1:0]      f_triv, mb;
    logic signed [31:0] ma;
    logic               triv;

    function automatic logic signed [31:0] rnd(input logic signed [PW-1:0] a,
                                               input logic signed [PW-1:0] b);
        logic signed [PW:0] s;
        s = {{1{a[PW-1]}}, a} + {{1{b[PW-1]}}, b} + (PW+1)'(1 << (FRAC_BITS - 1));
        return 32'(s >>> FRAC_BITS);
    endfunction

    always_comb begin
        n_cur  = i_cmd.axis ? r_ny : r_nx;
        q_cur  = i_cmd.axis ? r_qy : r_qx;
        c1v    = (q_cur <= r_lo) ? r_lo : q_cur;
        top    = (c1v >= r_rd);
        cv     = top ? r_rd : c1v;
        hit    = (r_rd >= r_c);
        last   = (r_k == KW'(n_cur - CW'(1)));
        dv     = 33'(r_rd) - 33'(r_t0);
        diff   = 33'(r_c) - 33'(r_t0);
        triv   = (dv <= 0) || (diff < 0) || (diff >= dv);
        f_triv = ((dv <= 0) || (diff < 0)) ? '0 : FRAC_ONE;
        rem2   = {r_rem, 1'b0};
        qbit   = (rem2 >= 34'(r_d));
        q_next = {r_q[FRAC_BITS-2:0], qbit};

        rd_addr = '0;
        case (i_cmd.op)
            OP_HI:    rd_addr = KW'(n_cur - CW'(1));
            OP_CLAMP: rd_addr = top ? KW'(n_cur - CW'(2)) : KW'(1);
            OP_SCAN:  rd_addr = hit ? r_k - KW'(1) : (last ? '0 : r_k + KW'(1));
            OP_R0:    rd_addr = r_idx + KW'(1);
            default:  rd_addr = '0;
        endcase

        g_addr = r_base;
        case (i_cmd.op)
            OP_M00:  g_addr = r_base + GAW'(r_ny);
            OP_M10:  g_addr = r_base + GAW'(1);
            OP_M01:  g_addr = r_base + GAW'(r_ny) + GAW'(1);
            default: g_addr = r_base;
        endcase

        ma = r_g;
        mb = FRAC_ONE - r_fx;
        case (i_cmd.op)
            OP_M10, OP_M11: mb = r_fx;
            OP_MU0: begin
                ma = r_c0;
                mb = FRAC_ONE - r_fy;
            end
            OP_MU1: begin
                ma = r_c1;
                mb = r_fy;
            end
            default: mb = FRAC_ONE - r_fx;
        endcase

        o_stat.top         = top;
        o_stat.scan_end    = hit || last;
        o_stat.div_trivial = triv;
        o_stat.div_last    = (r_cnt == DCW'(FRAC_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ACCEPT) begin
            if (i_kind == KIND_LOAD_X && 32'(i_entry_index) < MAX_X_POINTS) begin
                xt[i_entry_index[XAW-1:0]] <= i_entry_value;
            end
            if (i_kind == KIND_LOAD_Y && 32'(i_entry_index) < MAX_Y_POINTS) begin
                yt[i_entry_index[YAW-1:0]] <= i_entry_value;
            end
        end
        r_rd <= i_cmd.axis ? yt[rd_addr[YAW-1:0]] : xt[rd_addr[XAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ACCEPT && i_kind == KIND_LOAD_G
            && 32'(i_entry_index) < GRID_DEPTH) begin
            grid[i_entry_index[GAW-1:0]] <= i_entry_value;
        end
        r_g <= grid[g_addr];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_qx <= i_query_x;
                r_qy <= i_query_y;
                r_nx <= i_nx;
                r_ny <= i_ny;
            end
            OP_HI: r_lo <= r_rd;
            OP_CLAMP: begin
                r_c   <= cv;
                r_k   <= KW'(1);
                r_idx <= KW'(n_cur - CW'(2));
            end
            OP_SCAN: begin
                r_k <= r_k + KW'(1);
                if (hit) r_idx <= r_k - KW'(1);
                else if (last) r_idx <= '0;
            end
            OP_R0: r_t0 <= r_rd;
            OP_R1: begin
                r_d   <= dv;
                r_rem <= diff;
                r_q   <= '0;
                r_cnt <= '0;
                if (triv) begin
                    if (i_cmd.axis) begin
                        r_fy <= f_triv;
                        r_iy <= r_idx;
                    end else begin
                        r_fx <= f_triv;
                        r_ix <= r_idx;
                    end
                end
            end
            OP_DIV: begin
                r_rem <= qbit ? 33'(rem2 - 34'(r_d)) : 33'(rem2);
                r_q   <= q_next;
                r_cnt <= r_cnt + DCW'(1);
                if (r_cnt == DCW'(FRAC_BITS - 1)) begin
                    if (i_cmd.axis) begin
                        r_fy <= {1'b0, q_next};
                        r_iy <= r_idx;
                    end else begin
                        r_fx <= {1'b0, q_next};
                        r_ix <= r_idx;
                    end
                end
            end
            OP_GBASE: r_base <= GAW'(r_ix) * GAW'(r_ny) + GAW'(r_iy);
            OP_M10, OP_M11, OP_MU1: r_acc <= r_p;
            OP_M01: r_c0 <= rnd(r_acc, r_p);
            OP_C1:  r_c1 <= rnd(r_acc, r_p);
            OP_OUT: r_res <= rnd(r_acc, r_p);
            default: r_k <= r_k;
        endcase
        if (i_cmd.op != OP_NONE) r_p <= PW'(ma * $signed({1'b0, mb}));
    end

    assign o_result = r_res;

endmodule

// ----- rtl/clamped_bilinear_table_interp.sv -----
// Top level of the clamped bilinear table interpolator with its register port.
//
// Load beats (x axis, y axis or grid entry) are taken one per cycle while no query
// is in progress. Each axis is bracketed by a linear scan of its table memory at one
// entry per cycle, skipped when the query clamps to the last entry; each fraction
// not trivially 0 or 1 comes from a bit-serial divider at one quotient bit per
// cycle, and the blend runs four grid reads and six products through one multiplier.
// A finished result waits in the output register while the next beat is accepted.
module clamped_bilinear_table_interp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic [11:0]        i_entry_index,
    input  logic signed [31:0] i_entry_value,
    input  logic signed [31:0] i_query_x,
    input  logic signed [31:0] i_query_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_interpolated_value
);
    import cbti_pkg::*;

    logic [6:0] r_x_points, r_y_points;
    t_cmd       cmd;
    t_stat      stat;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_points <= 7'd2;
            r_y_points <= 7'd2;
        end else if (wr_en) begin
            if (paddr[2] == REG_X_POINTS) r_x_points <= pwdata[6:0];
            else r_y_points <= pwdata[6:0];
        end
    end

    assign prdata = (paddr[2] == REG_X_POINTS) ? {25'd0, r_x_points} : {25'd0, r_y_points};

    cbti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    cbti_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_query_x     (i_query_x),
        .i_query_y     (i_query_y),
        .i_nx          (eff_count(r_x_points, MAX_X_POINTS)),
        .i_ny          (eff_count(r_y_points, MAX_Y_POINTS)),
        .o_stat        (stat),
        .o_result      (o_interpolated_value)
    );

endmodule
